/* rtl/core/gas_pkg.sv */
package gas_pkg;

    // Payload widths of the request and response channels
    localparam int FUNC_W = 2;
    localparam int SLOT_W = 16;
    localparam int GEN_W  = 32;

    // Configuration port
    localparam int CFG_W       = 11;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SLOT_COUNT = 0;

    // Defaults of the top-level parameters
    localparam int MAX_SLOTS_DEFAULT = 1024;
    localparam int GEN_BITS_DEFAULT  = 32;
    localparam int SLOT_COUNT_RESET  = 1024;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd2;

    // Slot number reported by a failed acquire
    localparam logic [SLOT_W-1:0] SLOT_NONE = '1;

endpackage

/* rtl/core/gas_if.sv */
interface gas_req_if;
    logic                       valid;
    logic                       ready;
    logic [gas_pkg::FUNC_W-1:0] func;
    logic [gas_pkg::SLOT_W-1:0] slot;
    logic [gas_pkg::GEN_W-1:0]  generation;

    modport source (output valid, func, slot, generation, input ready);
    modport sink   (input valid, func, slot, generation, output ready);
endinterface

interface gas_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [gas_pkg::SLOT_W-1:0] slot_out;
    logic [gas_pkg::GEN_W-1:0]  generation_out;

    modport source (output valid, ok, slot_out, generation_out, input ready);
    modport sink   (input valid, ok, slot_out, generation_out, output ready);
endinterface

/* rtl/core/gas_ram.sv */
module gas_ram #(
    parameter int DEPTH = gas_pkg::MAX_SLOTS_DEFAULT,
    parameter int WIDTH = gas_pkg::GEN_BITS_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/gas_cfg.sv */
module gas_cfg #(
    parameter int MAX_SLOTS = gas_pkg::MAX_SLOTS_DEFAULT,
    localparam int AW       = $clog2(MAX_SLOTS),
    localparam int CW       = $clog2(MAX_SLOTS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gas_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gas_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [CW-1:0]                  slot_count,
    output logic                           sweep_busy,
    output logic [AW-1:0]                  sweep_addr,
    output logic [AW-1:0]                  sweep_slot
);

    localparam int CMPW = ((CW > gas_pkg::CFG_W) ? CW : gas_pkg::CFG_W) + 1;
    localparam int RESET_COUNT = (gas_pkg::SLOT_COUNT_RESET > MAX_SLOTS) ?
                                 MAX_SLOTS : gas_pkg::SLOT_COUNT_RESET;

    logic [CW-1:0]                 slot_count_reg, slot_count_next;
    logic                          busy_reg, busy_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [gas_pkg::CFG_W-1:0]     wr_value;
    logic [CW-1:0]                 wr_count;
    logic [CW-1:0]                 init_slot;
    logic                          sel_slot_count;
    logic                          wr_en;

    assign sel_slot_count = (paddr[gas_pkg::APB_ADDR_W-1] == 1'(gas_pkg::REG_SLOT_COUNT));
    assign wr_en          = psel && penable && pwrite && sel_slot_count;
    assign wr_value       = pwdata[gas_pkg::CFG_W-1:0];

    // Saturate the requested count to the pool size
    always_comb
    begin
        if (CMPW'(wr_value) > CMPW'(MAX_SLOTS))
        begin
            wr_count = CW'(MAX_SLOTS);
        end
        else
        begin
            wr_count = CW'(wr_value);
        end
    end

    // A write restarts the sweep from entry zero
    always_comb
    begin
        slot_count_next = slot_count_reg;
        busy_next       = busy_reg;
        addr_next       = addr_reg;
        if (busy_reg)
        begin
            addr_next = addr_reg + AW'(1);
            if (addr_reg == AW'(MAX_SLOTS - 1))
            begin
                busy_next = 1'b0;
            end
        end
        if (wr_en)
        begin
            slot_count_next = wr_count;
            busy_next       = 1'b1;
            addr_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CW'(RESET_COUNT);
            busy_reg       <= 1'b1;
            addr_reg       <= '0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            busy_reg       <= busy_next;
            addr_reg       <= addr_next;
        end
    end

    // Stack entry i starts as count-1-i, so slot 0 sits on top
    assign init_slot  = slot_count_reg - CW'(1) - CW'(addr_reg);

    assign slot_count = slot_count_reg;
    assign sweep_busy = busy_reg;
    assign sweep_addr = addr_reg;
    assign sweep_slot = init_slot[AW-1:0];
    assign pready     = 1'b1;
    assign prdata     = sel_slot_count ? gas_pkg::APB_DATA_W'(slot_count_reg) : '0;

endmodule

/* rtl/core/generation_tagged_slot_allocator.sv */
// An acquire passes a stack read, then a generation read, then the update that loads the
// result register; release and check take the generation read and then the update.
// A new request is taken only once the last item has left its read-modify-write sequence;
// a result still waiting in the output register holds the next item in its update step,
// so intake stalls until that result transfers.
// Reset, and every slot_count write, starts a sweep over all MAX_SLOTS entries that refills
// the stack and clears all generations; req.ready stays low until the sweep ends.
module generation_tagged_slot_allocator #(
    parameter int MAX_SLOTS = gas_pkg::MAX_SLOTS_DEFAULT,
    parameter int GEN_BITS  = gas_pkg::GEN_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gas_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gas_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    gas_req_if.sink                        req,
    gas_rsp_if.source                      rsp
);

    localparam int AW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int GW   = (GEN_BITS > gas_pkg::GEN_W) ? GEN_BITS : gas_pkg::GEN_W;
    localparam int SCW  = gas_pkg::SLOT_W + 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CW-1:0]               fc_reg, fc_next;
    logic [gas_pkg::FUNC_W-1:0]  func_reg;
    logic [gas_pkg::SLOT_W-1:0]  slot_reg;
    logic [gas_pkg::GEN_W-1:0]   gen_in_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_ok_reg;
    logic [gas_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [gas_pkg::GEN_W-1:0]   out_gen_reg;

    logic [CW-1:0]               slot_count;
    logic                        sweep_busy;
    logic [AW-1:0]               sweep_addr;
    logic [AW-1:0]               sweep_slot;

    logic                        accept;
    logic                        exec_go;
    logic [CW-1:0]               fc_dec;

    logic                        stack_we;
    logic [AW-1:0]               stack_waddr;
    logic [AW-1:0]               stack_wdata;
    logic [AW-1:0]               stack_rd;

    logic                        gen_we;
    logic                        gen_re;
    logic [AW-1:0]               gen_waddr;
    logic [GEN_BITS-1:0]         gen_wdata;
    logic [AW-1:0]               gen_raddr;
    logic [GEN_BITS-1:0]         gen_rd;
    logic [GEN_BITS-1:0]         gen_inc;
    logic [GW-1:0]               gen_rd_ext;
    logic [GW-1:0]               gen_inc_ext;
    logic [AW-1:0]               gen_tgt;

    logic                        avail;
    logic                        in_range;
    logic                        match;
    logic                        room;

    logic                        res_ok;
    logic [gas_pkg::SLOT_W-1:0]  res_slot;
    logic [gas_pkg::GEN_W-1:0]   res_gen;
    logic                        do_pop;
    logic                        do_push;
    logic                        do_gen;

    gas_cfg #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .slot_count (slot_count),
        .sweep_busy (sweep_busy),
        .sweep_addr (sweep_addr),
        .sweep_slot (sweep_slot)
    );

    // One item in flight at a time; the result register parts intake from output
    assign accept  = req.valid && req.ready;
    assign exec_go = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign fc_dec  = fc_reg - CW'(1);

    // Free stack: sweep owns the write port while it runs, else release pushes at the count
    assign stack_we    = sweep_busy || (exec_go && do_push);
    assign stack_waddr = sweep_busy ? sweep_addr : fc_reg[AW-1:0];
    assign stack_wdata = sweep_busy ? sweep_slot : slot_reg[AW-1:0];

    gas_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (AW)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (accept),
        .raddr (fc_dec[AW-1:0]),
        .rdata (stack_rd)
    );

    // Generation memory: an acquire reads at the popped slot, others at the request slot
    assign gen_tgt   = (func_reg == gas_pkg::FUNC_ACQUIRE) ? stack_rd : slot_reg[AW-1:0];
    assign gen_re    = accept || (state_reg == S_POP);
    assign gen_raddr = (state_reg == S_POP) ? stack_rd : req.slot[AW-1:0];
    assign gen_we    = sweep_busy || (exec_go && do_gen);
    assign gen_waddr = sweep_busy ? sweep_addr : gen_tgt;
    assign gen_wdata = sweep_busy ? '0 : gen_inc;

    gas_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (GEN_BITS)
    ) u_gen (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rd)
    );

    // Counters wrap at GEN_BITS; only the low 32 bits are compared and reported
    assign gen_inc     = gen_rd + GEN_BITS'(1);
    assign gen_rd_ext  = GW'(gen_rd);
    assign gen_inc_ext = GW'(gen_inc);

    assign avail    = (fc_reg != '0);
    assign in_range = ({1'b0, slot_reg} < SCW'(slot_count));
    assign match    = in_range && (gen_rd_ext[gas_pkg::GEN_W-1:0] == gen_in_reg);
    assign room     = (fc_reg < slot_count);

    // Result and side effects of the held item; committed only on exec_go
    always_comb
    begin
        res_ok   = 1'b0;
        res_slot = slot_reg;
        res_gen  = gen_in_reg;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_gen   = 1'b0;
        case (func_reg)
            gas_pkg::FUNC_ACQUIRE:
            begin
                if (avail)
                begin
                    res_ok   = 1'b1;
                    res_slot = gas_pkg::SLOT_W'(stack_rd);
                    res_gen  = gen_inc_ext[gas_pkg::GEN_W-1:0];
                    do_pop   = 1'b1;
                    do_gen   = 1'b1;
                end
                else
                begin
                    res_slot = gas_pkg::SLOT_NONE;
                    res_gen  = '0;
                end
            end
            gas_pkg::FUNC_RELEASE:
            begin
                // Refuse a stale, out-of-range or overflowing release
                if (match && room)
                begin
                    res_ok  = 1'b1;
                    do_push = 1'b1;
                    do_gen  = 1'b1;
                end
            end
            gas_pkg::FUNC_CHECK:
            begin
                res_ok = match;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.func == gas_pkg::FUNC_ACQUIRE) ? S_POP : S_EXEC;
                end
            end
            S_POP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // Hold while the previous result is still waiting
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sweep reloads the free count; otherwise pop or push by one
    always_comb
    begin
        fc_next = fc_reg;
        if (sweep_busy)
        begin
            fc_next = slot_count;
        end
        else if (exec_go && do_pop)
        begin
            fc_next = fc_dec;
        end
        else if (exec_go && do_push)
        begin
            fc_next = fc_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= req.func;
            slot_reg   <= req.slot;
            gen_in_reg <= req.generation;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_ok_reg   <= res_ok;
            out_slot_reg <= res_slot;
            out_gen_reg  <= res_gen;
        end
    end

    assign req.ready          = (state_reg == S_IDLE) && !sweep_busy;
    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.slot_out       = out_slot_reg;
    assign rsp.generation_out = out_gen_reg;

endmodule

/* tb/sv/slot_pool_check_pkg.sv */
`timescale 1ns / 100ps
package slot_pool_check_pkg;
    import gas_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot_out;
        logic [GEN_W-1:0]  generation_out;
    } pool_reply_t;

    // Mirror of the slot pool plus the queue of replies still owed by the block.
    class slot_pool_scoreboard;
        int unsigned       slot_count;
        int unsigned       free_count;
        logic [SLOT_W-1:0] free_stack [MAX_SLOTS_DEFAULT];
        logic [GEN_W-1:0]  slot_gen [MAX_SLOTS_DEFAULT];
        pool_reply_t       awaited [$];
        int unsigned       mismatches;
        int unsigned       granted;
        int unsigned       starved;
        int unsigned       released;
        int unsigned       refused;
        int unsigned       matched;

        function new();
            mismatches = 0;
            granted = 0;
            starved = 0;
            released = 0;
            refused = 0;
            matched = 0;
            reinit(SLOT_COUNT_RESET);
        endfunction

        // Refill the stack so that slot 0 is on top and clear all generations.
        function void reinit(int unsigned value);
            int unsigned n;
            n = value & ((1 << CFG_W) - 1);
            if (n > MAX_SLOTS_DEFAULT)
                n = MAX_SLOTS_DEFAULT;
            slot_count = n;
            for (int i = 0; i < MAX_SLOTS_DEFAULT; i++)
            begin
                free_stack[i] = '0;
                slot_gen[i] = '0;
            end
            for (int unsigned i = 0; i < n; i++)
                free_stack[i] = SLOT_W'(n - 1 - i);
            free_count = n;
        endfunction

        function bit is_current(logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen);
            if (slot >= slot_count)
                return 1'b0;
            return slot_gen[slot] == gen;
        endfunction

        // Predict the reply to one accepted request and update the mirror.
        function void note_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                   logic [GEN_W-1:0] gen);
            pool_reply_t       want;
            logic [SLOT_W-1:0] top;
            want.ok = 1'b0;
            want.slot_out = slot;
            want.generation_out = gen;
            case (func)
                FUNC_ACQUIRE:
                begin
                    if (free_count == 0)
                    begin
                        want.slot_out = SLOT_NONE;
                        want.generation_out = '0;
                        starved++;
                    end
                    else
                    begin
                        free_count--;
                        top = free_stack[free_count];
                        // 32-bit counter: wraps by its width
                        slot_gen[top] = slot_gen[top] + 1'b1;
                        want.ok = 1'b1;
                        want.slot_out = top;
                        want.generation_out = slot_gen[top];
                        granted++;
                    end
                end
                FUNC_RELEASE:
                begin
                    if (is_current(slot, gen) && free_count < slot_count)
                    begin
                        slot_gen[slot] = slot_gen[slot] + 1'b1;
                        free_stack[free_count] = slot;
                        free_count++;
                        want.ok = 1'b1;
                        released++;
                    end
                    else
                        refused++;
                end
                FUNC_CHECK:
                begin
                    want.ok = is_current(slot, gen);
                    if (want.ok)
                        matched++;
                end
                default:
                begin
                end
            endcase
            awaited.insert(awaited.size(), want);
        endfunction

        // Compare one reply transfer against the oldest prediction.
        function void check_reply(pool_reply_t got);
            pool_reply_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding: ok=%0b slot=%0d gen=%08h",
                         $time, got.ok, got.slot_out, got.generation_out);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.ok !== want.ok)
            begin
                $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
                mismatches++;
            end
            if (got.slot_out !== want.slot_out)
            begin
                $display("%0t: slot_out expected %0d actual %0d",
                         $time, want.slot_out, got.slot_out);
                mismatches++;
            end
            if (got.generation_out !== want.generation_out)
            begin
                $display("%0t: generation_out expected %08h actual %08h",
                         $time, want.generation_out, got.generation_out);
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
    import gas_pkg::*;
    import slot_pool_check_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_GAP         = 14;
    // Acquire passes a stack read and a generation read before its result register loads; leave ample margin
    localparam int SETTLE_CYCLES   = 16;
    // Slowest run is all the sweeps plus every item with its gaps; take it several times
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int PHASE_COUNT     = 12;

    // The one func code the block does not define
    localparam logic [FUNC_W-1:0] FUNC_UNDEFINED = 2'd3;

    // Pool sizes for the random phases: mostly small so that the stack empties and
    // fills often; 0 (no slots), 1024 and an over-range value that saturates.
    localparam int unsigned PHASE_SIZES [PHASE_COUNT] =
        '{3, 1, 16, 2, 40, 0, 1024, 7, 2047, 5, 100, 1};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gas_req_if req_ch ();
    gas_rsp_if rsp_ch ();

    generation_tagged_slot_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    slot_pool_scoreboard pool;
    int unsigned         cycle_count = 0;
    int unsigned         sent_items = 0;
    int unsigned         pool_settings = 1;
    // When set, both sides drop their idle gaps so transfers run back to back
    bit                  steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit hit, %0d replies outstanding",
                     $time, pool.awaited.size());
            $display("generation_tagged_slot_allocator: mismatch");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Drive one request; hold it until the transfer, then note it in the scoreboard.
    // valid is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                                input logic [GEN_W-1:0] gen);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.slot       <= slot;
        req_ch.generation <= gen;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pool.note_request(func, slot, gen);
        sent_items++;
    endtask

    // Drop valid, wait for every predicted reply, then let the pipeline settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pool.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of slot_count: setup phase, then access phase until pready.
    task automatic write_slot_count(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_SLOT_COUNT * 4);
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool.reinit(value);
        pool_settings++;
    endtask

    // Mostly well-formed traffic: acquires and releases/checks of in-range slots with
    // their live generation, plus stale tags, out-of-range slots and raw noise.
    task automatic random_request();
        int unsigned       pick;
        logic [FUNC_W-1:0] f;
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;
        pick = $urandom_range(0, 99);
        s = SLOT_W'($urandom_range(0, 65535));
        g = $urandom();
        if (pool.slot_count != 0 && pick < 82)
        begin
            s = SLOT_W'($urandom_range(0, pool.slot_count - 1));
            g = pool.slot_gen[s];
        end
        if (pick < 35)
            f = FUNC_ACQUIRE;
        else if (pick < 60)
            f = FUNC_RELEASE;
        else if (pick < 70)
        begin
            // stale tag: one behind the live value, or arbitrary
            f = FUNC_RELEASE;
            g = $urandom_range(0, 1) ? g - 1'b1 : $urandom();
        end
        else if (pick < 82)
        begin
            f = FUNC_CHECK;
            if ($urandom_range(0, 1))
                g = g - 1'b1;
        end
        else if (pick < 92)
        begin
            // slot beyond the pool; generation 0 would match a fresh in-range slot
            f = $urandom_range(0, 1) ? FUNC_RELEASE : FUNC_CHECK;
            s = SLOT_W'($urandom_range(pool.slot_count, 65535));
            g = $urandom_range(0, 1) ? '0 : $urandom();
        end
        else if (pick < 96)
            f = FUNC_UNDEFINED;
        else
            f = FUNC_W'($urandom_range(0, 3));
        send_request(f, s, g);
    endtask

    // Reply side: stall a random number of cycles per reply, then check the transfer.
    initial
    begin
        int unsigned stall;
        pool_reply_t got;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            got.ok             = rsp_ch.ok;
            got.slot_out       = rsp_ch.slot_out;
            got.generation_out = rsp_ch.generation_out;
            pool.check_reply(got);
        end
    end

    initial
    begin
        pool = new();
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_ACQUIRE;
        req_ch.slot       <= '0;
        req_ch.generation <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset pool of 1024: full stack, all generations zero.
        send_request(FUNC_CHECK, 16'd0, 32'd0);
        // Matching tag but stack already full: refused
        send_request(FUNC_RELEASE, 16'd0, 32'd0);
        send_request(FUNC_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);
        send_request(FUNC_CHECK, 16'd0, 32'd1);
        // Stale tag, then a good release, then the same release again
        send_request(FUNC_RELEASE, 16'd0, 32'd0);
        send_request(FUNC_RELEASE, 16'd0, 32'd1);
        send_request(FUNC_RELEASE, 16'd0, 32'd1);
        send_request(FUNC_CHECK, 16'd0, 32'd2);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);
        // Last slot in range and the first one out of range
        send_request(FUNC_CHECK, 16'd1023, 32'd0);
        send_request(FUNC_CHECK, 16'd1024, 32'd0);
        send_request(FUNC_RELEASE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_CHECK, 16'd0, 32'hFFFF_FFFF);
        send_request(FUNC_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF);

        // Empty pool: every acquire fails, every slot is out of range
        drain();
        write_slot_count(0);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);
        send_request(FUNC_CHECK, 16'd0, 32'd0);
        send_request(FUNC_RELEASE, 16'd0, 32'd0);

        // Single slot: drain it, fail on the empty stack, give it back, overfill
        drain();
        write_slot_count(1);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);
        send_request(FUNC_RELEASE, 16'd0, 32'd1);
        send_request(FUNC_RELEASE, 16'd0, 32'd2);
        send_request(FUNC_CHECK, 16'd0, 32'd2);

        // Over-range count saturates to the full pool
        drain();
        write_slot_count(2047);
        send_request(FUNC_CHECK, 16'd1023, 32'd0);
        send_request(FUNC_ACQUIRE, 16'd0, 32'd0);

        // Generation wrap needs 2^32 increments of one slot and is out of reach here.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            write_slot_count(PHASE_SIZES[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // redraw now and then, so stretches with no idling alternate with gaps
                if (i % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                random_request();
            end
            steady = 1'b0;
        end

        drain();
        $display("%0d requests over %0d pool sizes: %0d acquires granted, %0d on empty stack",
                 sent_items, pool_settings, pool.granted, pool.starved);
        $display("%0d releases taken, %0d refused, %0d checks matched",
                 pool.released, pool.refused, pool.matched);
        if (pool.mismatches == 0 && pool.awaited.size() == 0)
            $display("generation_tagged_slot_allocator: match");
        else
            $display("generation_tagged_slot_allocator: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/gas_pkg.sv
rtl/core/gas_if.sv
rtl/core/gas_ram.sv
rtl/core/gas_cfg.sv
rtl/core/generation_tagged_slot_allocator.sv
tb/sv/slot_pool_check_pkg.sv
tb/sv/tb_top.sv
